### rtl/core/mh64_pkg.sv
// Shared constants, command codes and status types for the MurmurHash64A block.
package mh64_pkg;

    localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
    localparam int          MUR_R    = 47;
    localparam logic [63:0] MUR_SEED = 64'h000A_13F3_4623_4624;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE  = 4'd0;
    localparam t_op OP_LOAD  = 4'd1;
    localparam t_op OP_MUL0  = 4'd2;
    localparam t_op OP_MUL1  = 4'd3;
    localparam t_op OP_MUL2  = 4'd4;
    localparam t_op OP_SEED  = 4'd5;
    localparam t_op OP_XWORD = 4'd6;
    localparam t_op OP_XMIX  = 4'd7;
    localparam t_op OP_FOLDW = 4'd8;
    localparam t_op OP_FOLDT = 4'd9;
    localparam t_op OP_HSET  = 4'd10;
    localparam t_op OP_XFIN  = 4'd11;
    localparam t_op OP_EMIT  = 4'd12;
    localparam t_op OP_CONT  = 4'd13;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic in_msg;
        logic full_word;
        logic no_bytes;
        logic last;
        logic out_full;
    } t_stat;

endpackage

### rtl/core/murmur2_64bit_hash.sv
// Top level of the streaming MurmurHash64A block with a fixed seed.
// One 64-bit multiply by M runs as steps MUL0, MUL1 and MUL2 on the shared 32x32 multiplier.
// A new item is accepted only in the idle state, once the previous item is finished.
// A message's first item also builds the seed from its length; the last item finalizes.
// The result waits in the output register as the next item runs; the next emit waits for it.
// Synchronous active-low reset clears the controller, the message flag and the output valid.
module murmur2_64bit_hash (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // [63:0] data_word, [67:64] valid_bytes, [99:68] msg_length, [103:100] zero
    input  logic [103:0]  i_s_axis_tdata,
    input  logic          i_s_axis_tlast,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [63:0] hash_value
    output logic [63:0]   o_m_axis_tdata
);

    mh64_pkg::t_cmd  cmd;
    mh64_pkg::t_stat stat;

    mh64_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    mh64_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (i_s_axis_tdata[63:0]),
        .i_nbytes    (i_s_axis_tdata[67:64]),
        .i_len       (i_s_axis_tdata[99:68]),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

### rtl/core/mh64_datapath.sv
// Datapath: item registers, shared 32x32 multiplier, running hash and output register.
module mh64_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mh64_pkg::t_cmd    i_cmd,
    input  logic [63:0]       i_word,
    input  logic [3:0]        i_nbytes,
    input  logic [31:0]       i_len,
    input  logic              i_last,
    input  logic              i_out_ready,
    output mh64_pkg::t_stat   o_stat,
    output logic              o_out_valid,
    output logic [63:0]       o_out_data
);

    logic [63:0] r_word;
    logic [3:0]  r_nbytes;
    logic        r_last;
    logic [63:0] r_x;
    logic [63:0] r_p;
    logic [63:0] r_hash;
    logic        r_in_msg;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] mask;
    logic [63:0] hash_fold;

    always_comb begin
        mul_a = r_x[31:0];
        mul_b = mh64_pkg::MUR_M[31:0];
        case (i_cmd.op)
            mh64_pkg::OP_MUL1: begin
                mul_b = mh64_pkg::MUR_M[63:32];
            end
            mh64_pkg::OP_MUL2: begin
                mul_a = r_x[63:32];
            end
            default: begin
                mul_a = r_x[31:0];
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            mask[i*8 +: 8] = (3'(i) < r_nbytes[2:0]) ? 8'hFF : 8'h00;
        end
    end

    assign hash_fold = r_hash ^ r_p;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mh64_pkg::OP_LOAD: begin
                r_word   <= i_word;
                r_nbytes <= i_nbytes;
                r_last   <= i_last;
                r_x      <= {32'b0, i_len};
            end
            mh64_pkg::OP_MUL0: begin
                r_p <= prod;
            end
            mh64_pkg::OP_MUL1, mh64_pkg::OP_MUL2: begin
                r_p <= r_p + {prod[31:0], 32'b0};
            end
            mh64_pkg::OP_SEED: begin
                r_hash <= mh64_pkg::MUR_SEED ^ r_p;
            end
            mh64_pkg::OP_XWORD: begin
                r_x <= r_word;
            end
            mh64_pkg::OP_XMIX: begin
                r_x <= r_p ^ (r_p >> mh64_pkg::MUR_R);
            end
            mh64_pkg::OP_FOLDW: begin
                r_hash <= hash_fold;
                r_x    <= hash_fold;
            end
            mh64_pkg::OP_FOLDT: begin
                r_x <= r_hash ^ (r_word & mask);
            end
            mh64_pkg::OP_HSET: begin
                r_hash <= r_p;
            end
            mh64_pkg::OP_XFIN: begin
                r_x <= r_hash ^ (r_hash >> mh64_pkg::MUR_R);
            end
            mh64_pkg::OP_EMIT: begin
                r_out_data <= r_p ^ (r_p >> mh64_pkg::MUR_R);
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == mh64_pkg::OP_EMIT) begin
                r_in_msg    <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cmd.op == mh64_pkg::OP_CONT) begin
                    r_in_msg <= 1'b1;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_stat.in_msg    = r_in_msg;
    assign o_stat.full_word = r_nbytes[3];
    assign o_stat.no_bytes  = (r_nbytes == 4'd0);
    assign o_stat.last      = r_last;
    assign o_stat.out_full  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/core/mh64_ctrl.sv
// Controller: sequences seed, word mix, tail fold and finalize through the shared multiplier.
module mh64_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mh64_pkg::t_stat   i_stat,
    output logic              o_in_ready,
    output mh64_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_SEED   = 4'd2;
    localparam logic [3:0] S_DISP   = 4'd3;
    localparam logic [3:0] S_MIX    = 4'd4;
    localparam logic [3:0] S_FOLDW  = 4'd5;
    localparam logic [3:0] S_HSET   = 4'd6;
    localparam logic [3:0] S_FINCHK = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] r_ret;
    logic [3:0] n_ret;
    logic [1:0] r_step;
    logic [1:0] n_step;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_step   = r_step;
        o_cmd.op = mh64_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = mh64_pkg::OP_LOAD;
                    if (i_stat.in_msg) begin
                        n_state = S_DISP;
                    end else begin
                        n_state = S_MUL;
                        n_ret   = S_SEED;
                    end
                end
            end
            S_MUL: begin
                case (r_step)
                    2'd0: o_cmd.op = mh64_pkg::OP_MUL0;
                    2'd1: o_cmd.op = mh64_pkg::OP_MUL1;
                    default: o_cmd.op = mh64_pkg::OP_MUL2;
                endcase
                if (r_step == 2'd2) begin
                    n_step  = 2'd0;
                    n_state = r_ret;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_SEED: begin
                o_cmd.op = mh64_pkg::OP_SEED;
                n_state  = S_DISP;
            end
            S_DISP: begin
                if (i_stat.full_word) begin
                    o_cmd.op = mh64_pkg::OP_XWORD;
                    n_state  = S_MUL;
                    n_ret    = S_MIX;
                end else if (!i_stat.no_bytes) begin
                    o_cmd.op = mh64_pkg::OP_FOLDT;
                    n_state  = S_MUL;
                    n_ret    = S_HSET;
                end else begin
                    n_state = S_FINCHK;
                end
            end
            S_MIX: begin
                o_cmd.op = mh64_pkg::OP_XMIX;
                n_state  = S_MUL;
                n_ret    = S_FOLDW;
            end
            S_FOLDW: begin
                o_cmd.op = mh64_pkg::OP_FOLDW;
                n_state  = S_MUL;
                n_ret    = S_HSET;
            end
            S_HSET: begin
                o_cmd.op = mh64_pkg::OP_HSET;
                n_state  = S_FINCHK;
            end
            S_FINCHK: begin
                if (i_stat.last) begin
                    o_cmd.op = mh64_pkg::OP_XFIN;
                    n_state  = S_MUL;
                    n_ret    = S_EMIT;
                end else begin
                    o_cmd.op = mh64_pkg::OP_CONT;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_full) begin
                    o_cmd.op = mh64_pkg::OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_step  <= n_step;
        end
    end

endmodule

### rtl/core/mh64_checker.sv
// Port-level checker for the MurmurHash64A block and its bind.
module mh64_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_axis_tvalid,
    input logic          o_s_axis_tready,
    input logic [103:0]  i_s_axis_tdata,
    input logic          i_s_axis_tlast,
    input logic          o_m_axis_tvalid,
    input logic          i_m_axis_tready,
    input logic [63:0]   o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("reset left output valid or input not ready");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again before item finished");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without an item in progress");

endmodule

bind murmur2_64bit_hash mh64_checker u_mh64_checker (.*);
